FILE: hdl/fppa_pkg.sv
// Package for the fixed partition placement allocator.
// Holds the word types, command and policy codes and the controller to datapath links.
// No dependencies.
package fppa_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    localparam int CMD_W    = 2;
    localparam int PIDX_W   = 4;
    localparam int SVAL_W   = 16;
    localparam int PNUM_W   = 5;
    localparam int POLICY_W = 2;
    localparam int COUNT_W  = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PIDX_W-1:0] partition_index;
        logic [SVAL_W-1:0] size_value;
    } t_in_word;

    typedef struct packed {
        logic              granted;
        logic [PNUM_W-1:0] partition_number;
    } t_out_word;

    typedef struct packed {
        logic load_en;
        logic clear_en;
        logic scan_start;
        logic scan_issue;
        logic result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_empty;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hdl/fppa_ctrl.sv
// Controller state machine of the allocator: accepts words and sequences the scan.
// Depends on fppa_pkg.
module fppa_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [fppa_pkg::CMD_W-1:0] i_command,
    output logic                     o_in_stall,
    input  fppa_pkg::t_dp_status     i_status,
    output fppa_pkg::t_dp_cmd        o_cmd
);
    import fppa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_LOAD:  o_cmd.load_en = 1'b1;
                        CMD_CLEAR: o_cmd.clear_en = 1'b1;
                        CMD_ALLOC: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = i_status.scan_empty ? ST_DONE : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_EVAL;
                end
            end
            // The last read is compared in this cycle.
            ST_EVAL: n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/fppa_dp.sv
// Datapath of the allocator: size memory, in-use marks, scan pointer, pick and result register.
// Depends on fppa_pkg.
module fppa_dp #(
    parameter int MAX_PARTITIONS = fppa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fppa_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fppa_pkg::t_in_word            i_in_word,
    input  logic [fppa_pkg::POLICY_W-1:0] i_policy,
    input  logic [fppa_pkg::COUNT_W-1:0]  i_count,
    input  fppa_pkg::t_dp_cmd             i_cmd,
    output fppa_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fppa_pkg::t_out_word           o_out_word
);
    import fppa_pkg::*;

    localparam int IDX_W  = (MAX_PARTITIONS > 2) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNTW_A = $clog2(MAX_PARTITIONS + 1);
    localparam int CNT_W  = (CNTW_A > COUNT_W) ? CNTW_A : COUNT_W;

    logic [SIZE_BITS-1:0]      r_mem [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] r_in_use;
    logic [IDX_W-1:0]          r_nf_pos;

    logic [IDX_W-1:0]     r_addr;
    logic [CNT_W-1:0]     r_left;
    logic [SIZE_BITS-1:0] r_req;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_free;
    logic                 r_rd_vld;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick_idx;
    logic [SIZE_BITS-1:0] r_pick_size;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic [CNT_W-1:0] w_count_ext;
    logic [CNT_W-1:0] w_n;
    logic [CNT_W-1:0] w_ld_ext;
    logic             w_ld_ok;
    logic [IDX_W-1:0] w_start;
    logic             w_wrap;
    logic             w_qual;
    logic             w_take;
    logic [IDX_W:0]   w_pnum_full;

    // Active count saturates at the table depth.
    assign w_count_ext = CNT_W'(i_count);
    assign w_n = (w_count_ext > CNT_W'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS) : w_count_ext;

    assign w_ld_ext = CNT_W'(i_in_word.partition_index);
    assign w_ld_ok  = (w_ld_ext < CNT_W'(MAX_PARTITIONS));

    // Next fit starts at the saved position unless it is stale.
    assign w_start = ((i_policy == POL_NEXT) && (CNT_W'(r_nf_pos) < w_n)) ? r_nf_pos : '0;
    assign w_wrap  = (CNT_W'(r_addr) == (w_n - CNT_W'(1)));

    assign w_qual = r_rd_vld && r_rd_free && (r_rd_data >= r_req);

    always_comb begin
        case (i_policy)
            POL_BEST:  w_take = w_qual && (!r_found || (r_rd_data < r_pick_size));
            POL_WORST: w_take = w_qual && (!r_found || (r_rd_data > r_pick_size));
            default:   w_take = w_qual && !r_found;
        endcase
    end

    assign w_pnum_full = {1'b0, r_pick_idx} + (IDX_W + 1)'(1);

    assign o_status.scan_empty = (w_n == '0);
    assign o_status.scan_last  = (r_left == CNT_W'(1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Size memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && w_ld_ok) begin
            r_mem[w_ld_ext[IDX_W-1:0]] <= SIZE_BITS'(i_in_word.size_value);
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr <= w_start;
            r_left <= w_n;
            r_req  <= SIZE_BITS'(i_in_word.size_value);
        end else if (i_cmd.scan_issue) begin
            r_addr <= w_wrap ? '0 : r_addr + IDX_W'(1);
            r_left <= r_left - CNT_W'(1);
        end
        r_rd_idx  <= r_addr;
        r_rd_free <= !r_in_use[r_addr];
        if (w_take) begin
            r_pick_idx  <= r_rd_idx;
            r_pick_size <= r_rd_data;
        end
        if (i_cmd.result_load) begin
            r_out_word.granted          <= r_found;
            r_out_word.partition_number <= r_found ? PNUM_W'(w_pnum_full) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_nf_pos    <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_start) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.clear_en) begin
                r_in_use <= '0;
                r_nf_pos <= '0;
            end else if (i_cmd.result_load && r_found) begin
                r_in_use[r_pick_idx] <= 1'b1;
                if (i_policy == POL_NEXT) begin
                    r_nf_pos <= r_pick_idx;
                end
            end
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/fixed_partition_placement_allocator.sv
// An allocate word is processed in steps from acceptance until its result is registered: a start
// step, one read per active partition on the size memory's read port, a compare of the last read
// and a load of the result once the output register is free. With a zero count the scan and the
// compare are skipped. Load and clear words are carried out when they are accepted.
// Input words are stalled while a request is in progress; a waiting result does not block
// load or clear words. Requests are searched by first, next, best or worst fit, and the
// result carries the 1-based partition number, or zero with granted low.
// Top level of the allocator: configuration registers, controller and datapath.
// Depends on fppa_pkg, fppa_ctrl and fppa_dp.
module fixed_partition_placement_allocator #(
    parameter int MAX_PARTITIONS = fppa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fppa_pkg::SIZE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  fppa_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output fppa_pkg::t_out_word         o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fppa_pkg::APB_AW-1:0] paddr,
    input  logic [fppa_pkg::APB_DW-1:0] pwdata,
    output logic [fppa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import fppa_pkg::*;

    logic [POLICY_W-1:0] r_policy;
    logic [COUNT_W-1:0]  r_count;
    logic                w_cfg_wr;
    logic                w_reg_sel;
    t_dp_cmd             w_cmd;
    t_dp_status          w_status;

    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_sel)
            REG_POLICY: prdata = APB_DW'(r_policy);
            REG_COUNT:  prdata = APB_DW'(r_count);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_count  <= COUNT_RESET;
        end else if (w_cfg_wr) begin
            if (w_reg_sel == REG_POLICY) begin
                r_policy <= pwdata[POLICY_W-1:0];
            end else begin
                r_count <= pwdata[COUNT_W-1:0];
            end
        end
    end

    fppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_word.command),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fppa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_policy    (r_policy),
        .i_count     (r_count),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // A result is only loaded when the output register is free or being emptied.
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result_load |-> w_status.out_free)
        else $error("result loaded over an untaken word");

    // Scanning never overlaps with accepting a new input word.
    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_issue |-> o_in_stall)
        else $error("input accepted during scan");

    // At most one datapath operation is commanded per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_en, w_cmd.clear_en, w_cmd.scan_start, w_cmd.scan_issue,
                  w_cmd.result_load}))
        else $error("conflicting datapath commands");

    // A refused request reports partition number zero.
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.granted) |-> (o_out_word.partition_number == '0))
        else $error("nonzero partition number without grant");

endmodule
